// File: sv/ntc_pkg.sv
// ntc_pkg: shared widths, types, register codes and the thermistor table
// for the ntc adc-to-temperature block; no dependencies
package ntc_pkg;

    // field widths
    localparam int unsigned RAW_W  = 12;
    localparam int unsigned CFG_W  = 24;
    localparam int unsigned TEMP_W = 12;
    localparam int unsigned CFG_IDX_W = 2;

    // default sizes handed to the top level parameters, and the stored table size
    localparam int unsigned ADC_FULL_SCALE_DEF = 4095;
    localparam int unsigned TABLE_ENTRIES_DEF  = 39;
    localparam int unsigned STORED_ENTRIES     = 39;

    // datapath widths
    localparam int unsigned PROD_W = CFG_W + RAW_W;     // series * raw
    localparam int unsigned NUM_W  = PROD_W + 10;       // series * 1000 * raw
    localparam int unsigned LIM_W  = CFG_W + 10;        // clamp limits in milliohms
    localparam int unsigned RES_W  = 33;                // table entries in milliohms
    localparam int unsigned Q_W    = RES_W + 6;         // 50 * (r - rlo)
    localparam int unsigned QT_W   = 6;                 // interpolation quotient, < 50
    localparam int unsigned TIDX_W = 6;                 // table index

    localparam int unsigned DIV_BITS_PER_CYCLE = 2;
    localparam int unsigned DIV_STEPS = NUM_W / DIV_BITS_PER_CYCLE;

    localparam int unsigned QUEUE_DEPTH = 2;

    // scaling constants
    localparam logic [9:0] MOHM_PER_OHM = 10'd1000;
    localparam logic [5:0] INTERP_STEP  = 6'd50;
    localparam int ENTRY_T0   = -400;
    localparam int ENTRY_STEP = 50;

    // register reset values
    localparam logic [CFG_W-1:0] SERIES_RES_RST = 24'd100000;
    localparam logic [CFG_W-1:0] MIN_RES_RST    = 24'd1279;
    localparam logic [CFG_W-1:0] MAX_RES_RST    = 24'd6120926;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SERIES_RES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_RES    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RES    = 2'd2;

    // sample class set by the front end
    typedef enum logic [1:0] {
        KIND_DIV  = 2'd0,
        KIND_ZERO = 2'd1,
        KIND_SAT  = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [RAW_W-1:0]  raw;
    } item_t;

    typedef struct packed {
        logic [CFG_W-1:0] series_res_ohms;
        logic [CFG_W-1:0] min_res_ohms;
        logic [CFG_W-1:0] max_res_ohms;
    } cfg_t;

    typedef struct packed {
        logic busy;
        logic res_load;
    } bk_stat_t;

    // thermistor resistance in milliohms, -40 C to 150 C in 5 C steps
    function automatic logic [RES_W-1:0] ntc_res_mohm(input logic [TIDX_W-1:0] idx);
        logic [RES_W-1:0] v;
        case (idx)
            6'd0:  v = 33'd6120926223;
            6'd1:  v = 33'd4118517102;
            6'd2:  v = 33'd2816706280;
            6'd3:  v = 33'd1956101683;
            6'd4:  v = 33'd1378149975;
            6'd5:  v = 33'd984222443;
            6'd6:  v = 33'd711944165;
            6'd7:  v = 33'd521247164;
            6'd8:  v = 33'd386009986;
            6'd9:  v = 33'd288963585;
            6'd10: v = 33'd218539022;
            6'd11: v = 33'd166887948;
            6'd12: v = 33'd128622111;
            6'd13: v = 33'd100000000;
            6'd14: v = 33'd78395360;
            6'd15: v = 33'd61945701;
            6'd16: v = 33'd49317168;
            6'd17: v = 33'd39545515;
            6'd18: v = 33'd31927436;
            6'd19: v = 33'd25945549;
            6'd20: v = 33'd21216133;
            6'd21: v = 33'd17452359;
            6'd22: v = 33'd14438219;
            6'd23: v = 33'd12009867;
            6'd24: v = 33'd10042166;
            6'd25: v = 33'd8438910;
            6'd26: v = 33'd7125667;
            6'd27: v = 33'd6044495;
            6'd28: v = 33'd5150030;
            6'd29: v = 33'd4406551;
            6'd30: v = 33'd3785776;
            6'd31: v = 33'd3265202;
            6'd32: v = 33'd2826827;
            6'd33: v = 33'd2456185;
            6'd34: v = 33'd2141593;
            6'd35: v = 33'd1873575;
            6'd36: v = 33'd1644412;
            6'd37: v = 33'd1447789;
            6'd38: v = 33'd1278518;
            default: v = '0;
        endcase
        return v;
    endfunction

    // temperature of a table entry in tenths of a degree
    function automatic logic signed [TEMP_W-1:0] ntc_entry_tenths(
        input logic [TIDX_W-1:0] idx
    );
        int v;
        v = ENTRY_T0 + ENTRY_STEP * int'(idx);
        return TEMP_W'(v);
    endfunction

endpackage

// File: sv/ntc_front.sv
// ntc_front: input stage that takes samples and tags them as saturated,
// zero or needing a divide; depends on ntc_pkg
module ntc_front #(
    parameter int unsigned ADC_FULL_SCALE = ntc_pkg::ADC_FULL_SCALE_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic [ntc_pkg::RAW_W-1:0]  raw_sample,
    input  logic                       q_full,
    output logic                       q_push,
    output ntc_pkg::item_t             q_data
);

    localparam int unsigned FS_W = $clog2(ADC_FULL_SCALE + 1);
    localparam int unsigned CW   = (FS_W > ntc_pkg::RAW_W) ? FS_W : ntc_pkg::RAW_W;
    localparam logic [CW-1:0] FS_C = CW'(ADC_FULL_SCALE);

    logic            valid_reg, valid_next;
    ntc_pkg::item_t  item_reg, item_next;
    logic            accept;
    ntc_pkg::kind_t  kind;

    // classify the incoming sample
    always_comb
    begin
        if (CW'(raw_sample) >= FS_C)
            kind = ntc_pkg::KIND_SAT;
        else if (raw_sample == '0)
            kind = ntc_pkg::KIND_ZERO;
        else
            kind = ntc_pkg::KIND_DIV;
    end

    // handshake toward the producer and the queue
    assign full   = valid_reg && q_full;
    assign accept = push && !full;
    assign q_push = valid_reg && !q_full;
    assign q_data = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (accept)
        begin
            valid_next = 1'b1;
            item_next  = '{kind: kind, raw: raw_sample};
        end
        else if (q_push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

endmodule

// File: sv/ntc_queue.sv
// ntc_queue: short queue of tagged samples between front and back end
// depends on ntc_pkg
module ntc_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  ntc_pkg::item_t  wr_data,
    output logic            full,
    input  logic            rd_en,
    output ntc_pkg::item_t  rd_data,
    output logic            empty
);

    localparam int unsigned DEPTH = ntc_pkg::QUEUE_DEPTH;
    localparam int unsigned PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNTW  = $clog2(DEPTH + 1);
    localparam logic [PW-1:0]   PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CNTW-1:0] CNT_FULL = CNTW'(DEPTH);

    ntc_pkg::item_t   mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0]  cnt_reg, cnt_next;
    logic             do_wr, do_rd;

    assign full    = (cnt_reg == CNT_FULL);
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            cnt_next = cnt_reg + 1'b1;
        else if (do_rd && !do_wr)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

// File: sv/ntc_back.sv
// ntc_back: sequencer that computes resistance, clamps it, searches the
// table and interpolates; holds the result register; depends on ntc_pkg
module ntc_back #(
    parameter int unsigned ADC_FULL_SCALE = ntc_pkg::ADC_FULL_SCALE_DEF,
    parameter int unsigned TABLE_ENTRIES  = ntc_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  ntc_pkg::cfg_t                      cfg,
    input  logic                               q_empty,
    input  ntc_pkg::item_t                     q_data,
    output logic                               q_pop,
    output logic                               empty,
    input  logic                               pop,
    output logic signed [ntc_pkg::TEMP_W-1:0]  temp_tenths,
    output logic                               was_clamped,
    output ntc_pkg::bk_stat_t                  stat
);

    localparam int unsigned RAW_W  = ntc_pkg::RAW_W;
    localparam int unsigned NUM_W  = ntc_pkg::NUM_W;
    localparam int unsigned PROD_W = ntc_pkg::PROD_W;
    localparam int unsigned LIM_W  = ntc_pkg::LIM_W;
    localparam int unsigned RES_W  = ntc_pkg::RES_W;
    localparam int unsigned Q_W    = ntc_pkg::Q_W;
    localparam int unsigned QT_W   = ntc_pkg::QT_W;
    localparam int unsigned TIDX_W = ntc_pkg::TIDX_W;
    localparam int unsigned TEMP_W = ntc_pkg::TEMP_W;

    localparam int unsigned FS_W = $clog2(ADC_FULL_SCALE + 1);
    localparam int unsigned CW   = (FS_W > RAW_W) ? FS_W : RAW_W;
    localparam logic [CW-1:0] FS_C = CW'(ADC_FULL_SCALE);

    localparam int unsigned NENT = (TABLE_ENTRIES < ntc_pkg::STORED_ENTRIES) ?
                                   TABLE_ENTRIES : ntc_pkg::STORED_ENTRIES;
    localparam int unsigned IW   = $clog2(NENT + 1);
    localparam logic [IW-1:0]     NENT_C = IW'(NENT);
    localparam logic [TIDX_W-1:0] LAST_C = TIDX_W'(NENT - 1);

    localparam int unsigned CNT_W = $clog2(ntc_pkg::DIV_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ntc_pkg::DIV_STEPS - 1);
    localparam int unsigned IQ_CW = $clog2(QT_W);
    localparam logic [IQ_CW-1:0] IQ_LAST = IQ_CW'(QT_W - 1);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_MUL1   = 9'b000000010,
        S_MUL2   = 9'b000000100,
        S_DIV    = 9'b000001000,
        S_CLAMP  = 9'b000010000,
        S_SEARCH = 9'b000100000,
        S_DIFF   = 9'b001000000,
        S_IDIV   = 9'b010000000,
        S_DONE   = 9'b100000000
    } state_t;

    state_t                    state_reg, state_next;
    ntc_pkg::kind_t            kind_reg, kind_next;
    logic [RAW_W-1:0]          raw_reg, raw_next;
    logic [FS_W-1:0]           dvs_reg, dvs_next;
    logic [PROD_W-1:0]         prod_reg, prod_next;
    logic [LIM_W-1:0]          lo_reg, lo_next;
    logic [LIM_W-1:0]          hi_reg, hi_next;
    logic [NUM_W-1:0]          num_reg, num_next;
    logic [FS_W-1:0]           rem_reg, rem_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [LIM_W-1:0]          r_reg, r_next;
    logic                      clamp_reg, clamp_next;
    logic [IW-1:0]             bs_lo_reg, bs_lo_next;
    logic [IW-1:0]             bs_hi_reg, bs_hi_next;
    logic [RES_W-1:0]          rlo_reg, rlo_next;
    logic [RES_W-1:0]          rhi_reg, rhi_next;
    logic [Q_W-1:0]            iq_rem_reg, iq_rem_next;
    logic [Q_W-1:0]            iq_dsh_reg, iq_dsh_next;
    logic [QT_W-1:0]           iq_quot_reg, iq_quot_next;
    logic [IQ_CW-1:0]          iq_cnt_reg, iq_cnt_next;
    logic signed [TEMP_W-1:0]  t_reg, t_next;
    logic                      out_valid_reg, out_valid_next;
    logic signed [TEMP_W-1:0]  out_temp_reg, out_temp_next;
    logic                      out_clamp_reg, out_clamp_next;

    // two restoring divide steps per cycle
    logic [FS_W:0]    dv_t1, dv_t2;
    logic [FS_W-1:0]  dv_r1, dv_r2;
    logic             dv_q1, dv_q2;

    always_comb
    begin
        dv_t1 = {rem_reg, num_reg[NUM_W-1]};
        dv_q1 = (dv_t1 >= {1'b0, dvs_reg});
        dv_r1 = dv_q1 ? FS_W'(dv_t1 - {1'b0, dvs_reg}) : FS_W'(dv_t1);
        dv_t2 = {dv_r1, num_reg[NUM_W-2]};
        dv_q2 = (dv_t2 >= {1'b0, dvs_reg});
        dv_r2 = dv_q2 ? FS_W'(dv_t2 - {1'b0, dvs_reg}) : FS_W'(dv_t2);
    end

    // binary search midpoint and table reads
    logic [IW:0]          bs_sum;
    logic [IW-1:0]        bs_mid;
    logic [RES_W-1:0]     tab_mid;
    logic [TIDX_W-1:0]    idx_ext;

    always_comb
    begin
        bs_sum  = {1'b0, bs_lo_reg} + {1'b0, bs_hi_reg};
        bs_mid  = bs_sum[IW:1];
        tab_mid = ntc_pkg::ntc_res_mohm(TIDX_W'(bs_mid));
        idx_ext = TIDX_W'(bs_lo_reg);
    end

    // interpolation divide step and final temperature
    logic                      iq_ge;
    logic [Q_W-1:0]            iq_rem_sub;
    logic [QT_W-1:0]           iq_quot_new;
    logic signed [TEMP_W-1:0]  base_t;
    logic [TEMP_W-1:0]         ce;

    always_comb
    begin
        iq_ge       = (iq_rem_reg >= iq_dsh_reg);
        iq_rem_sub  = iq_ge ? iq_rem_reg - iq_dsh_reg : iq_rem_reg;
        iq_quot_new = {iq_quot_reg[QT_W-2:0], iq_ge};
        base_t      = ntc_pkg::ntc_entry_tenths(idx_ext);
        // round up toward zero above 0 C
        ce = TEMP_W'(iq_quot_new)
           + TEMP_W'((base_t > 0) && (iq_rem_sub != '0));
    end

    logic res_load;
    assign res_load = (state_reg == S_DONE) && (!out_valid_reg || pop);

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        kind_next    = kind_reg;
        raw_next     = raw_reg;
        dvs_next     = dvs_reg;
        prod_next    = prod_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        num_next     = num_reg;
        rem_next     = rem_reg;
        cnt_next     = cnt_reg;
        r_next       = r_reg;
        clamp_next   = clamp_reg;
        bs_lo_next   = bs_lo_reg;
        bs_hi_next   = bs_hi_reg;
        rlo_next     = rlo_reg;
        rhi_next     = rhi_reg;
        iq_rem_next  = iq_rem_reg;
        iq_dsh_next  = iq_dsh_reg;
        iq_quot_next = iq_quot_reg;
        iq_cnt_next  = iq_cnt_reg;
        t_next       = t_reg;
        q_pop        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    kind_next  = q_data.kind;
                    raw_next   = q_data.raw;
                    dvs_next   = FS_W'(FS_C - CW'(q_data.raw));
                    rem_next   = '0;
                    state_next = S_MUL1;
                end
            end
            S_MUL1:
            begin
                prod_next = PROD_W'(cfg.series_res_ohms) * PROD_W'(raw_reg);
                lo_next   = LIM_W'(cfg.min_res_ohms) * LIM_W'(ntc_pkg::MOHM_PER_OHM);
                hi_next   = LIM_W'(cfg.max_res_ohms) * LIM_W'(ntc_pkg::MOHM_PER_OHM);
                case (kind_reg)
                    ntc_pkg::KIND_SAT:
                    begin
                        num_next   = '1;
                        state_next = S_CLAMP;
                    end
                    ntc_pkg::KIND_ZERO:
                    begin
                        num_next   = '0;
                        state_next = S_CLAMP;
                    end
                    default:
                    begin
                        state_next = S_MUL2;
                    end
                endcase
            end
            S_MUL2:
            begin
                num_next   = NUM_W'(prod_reg) * NUM_W'(ntc_pkg::MOHM_PER_OHM);
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                num_next = {num_reg[NUM_W-3:0], dv_q1, dv_q2};
                rem_next = dv_r2;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                    state_next = S_CLAMP;
            end
            S_CLAMP:
            begin
                // lower limit wins over the upper one
                if (num_reg < NUM_W'(lo_reg))
                begin
                    r_next     = lo_reg;
                    clamp_next = 1'b1;
                end
                else if (num_reg > NUM_W'(hi_reg))
                begin
                    r_next     = hi_reg;
                    clamp_next = 1'b1;
                end
                else
                begin
                    r_next     = LIM_W'(num_reg);
                    clamp_next = 1'b0;
                end
                bs_lo_next = '0;
                bs_hi_next = NENT_C;
                state_next = S_SEARCH;
            end
            S_SEARCH:
            begin
                if (bs_lo_reg == bs_hi_reg)
                begin
                    rlo_next   = ntc_pkg::ntc_res_mohm(idx_ext);
                    rhi_next   = ntc_pkg::ntc_res_mohm(idx_ext - 1'b1);
                    state_next = S_DIFF;
                end
                else if (r_reg >= LIM_W'(tab_mid))
                begin
                    bs_hi_next = bs_mid;
                end
                else
                begin
                    bs_lo_next = bs_mid + 1'b1;
                end
            end
            S_DIFF:
            begin
                if (bs_lo_reg == NENT_C)
                begin
                    // colder than every searched entry is not possible here;
                    // below the hottest entry gives the last temperature
                    t_next     = ntc_pkg::ntc_entry_tenths(LAST_C);
                    state_next = S_DONE;
                end
                else if ((r_reg == LIM_W'(rlo_reg)) || (bs_lo_reg == '0))
                begin
                    t_next     = base_t;
                    state_next = S_DONE;
                end
                else
                begin
                    iq_rem_next  = Q_W'(r_reg - LIM_W'(rlo_reg))
                                 * Q_W'(ntc_pkg::INTERP_STEP);
                    iq_dsh_next  = Q_W'(rhi_reg - rlo_reg) << (QT_W - 1);
                    iq_quot_next = '0;
                    iq_cnt_next  = '0;
                    state_next   = S_IDIV;
                end
            end
            S_IDIV:
            begin
                iq_rem_next  = iq_rem_sub;
                iq_dsh_next  = iq_dsh_reg >> 1;
                iq_quot_next = iq_quot_new;
                iq_cnt_next  = iq_cnt_reg + 1'b1;
                if (iq_cnt_reg == IQ_LAST)
                begin
                    t_next     = base_t - $signed(ce);
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (res_load)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_temp_next  = out_temp_reg;
        out_clamp_next = out_clamp_reg;
        if (res_load)
        begin
            out_valid_next = 1'b1;
            out_temp_next  = t_reg;
            out_clamp_next = clamp_reg;
        end
        else if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign empty         = !out_valid_reg;
    assign temp_tenths   = out_temp_reg;
    assign was_clamped   = out_clamp_reg;
    assign stat.busy     = (state_reg != S_IDLE);
    assign stat.res_load = res_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        raw_reg       <= raw_next;
        dvs_reg       <= dvs_next;
        prod_reg      <= prod_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        num_reg       <= num_next;
        rem_reg       <= rem_next;
        cnt_reg       <= cnt_next;
        r_reg         <= r_next;
        clamp_reg     <= clamp_next;
        bs_lo_reg     <= bs_lo_next;
        bs_hi_reg     <= bs_hi_next;
        rlo_reg       <= rlo_next;
        rhi_reg       <= rhi_next;
        iq_rem_reg    <= iq_rem_next;
        iq_dsh_reg    <= iq_dsh_next;
        iq_quot_reg   <= iq_quot_next;
        iq_cnt_reg    <= iq_cnt_next;
        t_reg         <= t_next;
        out_temp_reg  <= out_temp_next;
        out_clamp_reg <= out_clamp_next;
    end

endmodule

// File: sv/ntc_adc_to_temperature.sv
// ntc_adc_to_temperature: top level with configuration registers, front end,
// sample queue and back end; depends on ntc_pkg, ntc_front, ntc_queue, ntc_back
//
//  channel   direction  handshake           payload
//  samples   in         push / full         raw_sample
//  results   out        empty / pop         temp_tenths, was_clamped
//  config    in         cfg_we              cfg_index, cfg_wdata
//
// In the back end a sample passes the restoring divider (two quotient bits a
// cycle), a binary table search and an interpolation divide; zero and
// full-scale samples skip the divider. The front end and a two-entry queue
// keep taking samples while the back end works or while a result waits.
// Reset empties both sides and loads the register defaults; no clearing pass
// is needed.
module ntc_adc_to_temperature #(
    parameter int unsigned ADC_FULL_SCALE = ntc_pkg::ADC_FULL_SCALE_DEF,
    parameter int unsigned TABLE_ENTRIES  = ntc_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  logic [ntc_pkg::RAW_W-1:0]             raw_sample,
    output logic                                  empty,
    input  logic                                  pop,
    output logic signed [ntc_pkg::TEMP_W-1:0]     temp_tenths,
    output logic                                  was_clamped,
    input  logic                                  cfg_we,
    input  logic [ntc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [ntc_pkg::CFG_W-1:0]             cfg_wdata
);

    ntc_pkg::cfg_t      cfg_reg, cfg_next;
    logic               q_push, q_full, q_pop, q_empty;
    ntc_pkg::item_t     q_wdata, q_rdata;
    ntc_pkg::bk_stat_t  stat;

    // configuration register write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                ntc_pkg::REG_SERIES_RES: cfg_next.series_res_ohms = cfg_wdata;
                ntc_pkg::REG_MIN_RES:    cfg_next.min_res_ohms    = cfg_wdata;
                ntc_pkg::REG_MAX_RES:    cfg_next.max_res_ohms    = cfg_wdata;
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.series_res_ohms <= ntc_pkg::SERIES_RES_RST;
            cfg_reg.min_res_ohms    <= ntc_pkg::MIN_RES_RST;
            cfg_reg.max_res_ohms    <= ntc_pkg::MAX_RES_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // sample intake and classification
    ntc_front #(
        .ADC_FULL_SCALE (ADC_FULL_SCALE)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .raw_sample (raw_sample),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (q_wdata)
    );

    // queue between front and back end
    ntc_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wdata),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (q_rdata),
        .empty   (q_empty)
    );

    // conversion sequencer and result register
    ntc_back #(
        .ADC_FULL_SCALE (ADC_FULL_SCALE),
        .TABLE_ENTRIES  (TABLE_ENTRIES)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_empty     (q_empty),
        .q_data      (q_rdata),
        .q_pop       (q_pop),
        .empty       (empty),
        .pop         (pop),
        .temp_tenths (temp_tenths),
        .was_clamped (was_clamped),
        .stat        (stat)
    );

    // front end never pushes into a full queue
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("push into full queue");

    // back end only takes an item from a non-empty queue while idle
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (!q_empty && !stat.busy))
        else $error("queue read while busy or empty");

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        stat.res_load |-> (empty || pop))
        else $error("result overwritten");

    // a transfer with no new result leaves the output empty
    a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && !stat.res_load) |=> empty)
        else $error("result still shown after transfer");

endmodule

// File: dv/ntc_adc_to_temperature_tb.sv
// ntc_adc_to_temperature_tb: self-checking testbench for the ntc adc-to-temperature
// block; drives samples and register writes, predicts each temperature and checks it
// depends on ntc_pkg and ntc_adc_to_temperature
`timescale 1ns / 100ps

module ntc_adc_to_temperature_tb;
    import ntc_pkg::*;

    localparam longint unsigned FULL_SCALE = ADC_FULL_SCALE_DEF;
    localparam int SEARCH_N = (TABLE_ENTRIES_DEF > 39) ? 39 : TABLE_ENTRIES_DEF;
    localparam int COLD_TENTHS = -400;
    localparam int STEP_TENTHS = 50;
    localparam int STALL_CYCLES = 300;
    localparam int DRAIN_CYCLES = 60;
    localparam logic [CFG_W-1:0] CFG_MAX = {CFG_W{1'b1}};

    // thermistor curve in milliohms, -40 C to 150 C in 5 C steps
    localparam logic [63:0] CURVE_MOHM [0:38] = '{
        64'd6120926223, 64'd4118517102, 64'd2816706280, 64'd1956101683, 64'd1378149975,
        64'd984222443, 64'd711944165, 64'd521247164, 64'd386009986, 64'd288963585,
        64'd218539022, 64'd166887948, 64'd128622111, 64'd100000000, 64'd78395360,
        64'd61945701, 64'd49317168, 64'd39545515, 64'd31927436, 64'd25945549,
        64'd21216133, 64'd17452359, 64'd14438219, 64'd12009867, 64'd10042166,
        64'd8438910, 64'd7125667, 64'd6044495, 64'd5150030, 64'd4406551,
        64'd3785776, 64'd3265202, 64'd2826827, 64'd2456185, 64'd2141593,
        64'd1873575, 64'd1644412, 64'd1447789, 64'd1278518
    };

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp;
        logic                     clamped;
    } temp_result_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     push = 1'b0;
    logic                     full;
    logic [RAW_W-1:0]         raw_sample = '0;
    logic                     empty;
    logic                     pop = 1'b0;
    logic signed [TEMP_W-1:0] temp_tenths;
    logic                     was_clamped;
    logic                     cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index = REG_SERIES_RES;
    logic [CFG_W-1:0]         cfg_wdata = '0;

    // register copies used by the temperature predictor
    logic [CFG_W-1:0] series_ohms = SERIES_RES_RST;
    logic [CFG_W-1:0] min_ohms = MIN_RES_RST;
    logic [CFG_W-1:0] max_ohms = MAX_RES_RST;

    temp_result_t expected_temps[$];
    int errors = 0;
    int samples_sent = 0;
    int temps_checked = 0;
    int settings_used = 1;
    int stall_requests = 0;
    int stall_seen = 0;
    int hold_left = 0;
    int pop_gap_left = 0;

    ntc_adc_to_temperature DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .raw_sample  (raw_sample),
        .empty       (empty),
        .pop         (pop),
        .temp_tenths (temp_tenths),
        .was_clamped (was_clamped),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata)
    );

    // clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // run limit
    initial
    begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

    // idle length: mostly none or short, now and then long
    function automatic int draw_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50)
            return 0;
        else if (p < 85)
            return $urandom_range(1, 3);
        else if (p < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 80);
    endfunction

    // temperature for one sample under the current register values
    function automatic temp_result_t predict_temp(input logic [RAW_W-1:0] raw);
        logic [63:0] res;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] span;
        logic [63:0] q;
        logic [63:0] fl;
        int idx;
        int base;
        int t;
        bit hit;
        temp_result_t pred;
        pred.clamped = 1'b0;
        lo = 64'(min_ohms) * 64'd1000;
        hi = 64'(max_ohms) * 64'd1000;
        if (64'(raw) >= FULL_SCALE)
            res = '1;
        else
            res = (64'(series_ohms) * 64'd1000 * 64'(raw)) / (FULL_SCALE - 64'(raw));
        // lower limit wins when both apply
        if (res < lo)
        begin
            res = lo;
            pred.clamped = 1'b1;
        end
        else if (res > hi)
        begin
            res = hi;
            pred.clamped = 1'b1;
        end
        // first entry not above the resistance
        hit = 1'b0;
        idx = 0;
        for (int k = 0; k < SEARCH_N; k++)
        begin
            if (!hit && res >= CURVE_MOHM[k])
            begin
                hit = 1'b1;
                idx = k;
            end
        end
        base = COLD_TENTHS + STEP_TENTHS * idx;
        if (!hit)
            t = COLD_TENTHS + STEP_TENTHS * (SEARCH_N - 1);
        else if (res == CURVE_MOHM[idx] || idx == 0)
            t = base;
        else
        begin
            // truncate toward zero: round the step up above zero
            span = CURVE_MOHM[idx - 1] - CURVE_MOHM[idx];
            q = 64'd50 * (res - CURVE_MOHM[idx]);
            fl = q / span;
            if (base > 0)
                t = base - int'(fl) - ((q % span) != 0 ? 1 : 0);
            else
                t = base - int'(fl);
        end
        pred.temp = TEMP_W'(t);
        return pred;
    endfunction

    // result checker and pop driver
    always @(posedge clk)
    begin
        temp_result_t want;
        logic next_pop;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                temps_checked++;
                if (expected_temps.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual temp %0d clamped %0b",
                             $time, temp_tenths, was_clamped);
                end
                else
                begin
                    want = expected_temps.pop_front();
                    if (temp_tenths !== want.temp)
                    begin
                        errors++;
                        $display("%0t: temp_tenths mismatch, expected %0d, actual %0d",
                                 $time, want.temp, temp_tenths);
                    end
                    if (was_clamped !== want.clamped)
                    begin
                        errors++;
                        $display("%0t: was_clamped mismatch, expected %0b, actual %0b",
                                 $time, want.clamped, was_clamped);
                    end
                end
            end
            // long hold-off on request, otherwise random gaps after each transfer
            if (stall_requests != stall_seen)
            begin
                stall_seen = stall_requests;
                hold_left = STALL_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                next_pop = 1'b0;
            end
            else if (pop_gap_left > 0)
            begin
                pop_gap_left--;
                next_pop = 1'b0;
            end
            else
            begin
                next_pop = 1'b1;
                if (pop && !empty)
                begin
                    pop_gap_left = draw_gap();
                    if (pop_gap_left > 0)
                    begin
                        pop_gap_left--;
                        next_pop = 1'b0;
                    end
                end
            end
            pop <= next_pop;
        end
    end

    // offer one sample until transferred, then idle for the given gap
    task automatic send_sample(input logic [RAW_W-1:0] raw, input int gap);
        push <= 1'b1;
        raw_sample <= raw;
        @(posedge clk);
        while (full)
            @(posedge clk);
        expected_temps.push_back(predict_temp(raw));
        samples_sent++;
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // stop offering and wait for every pending temperature
    task automatic wait_drained();
        push <= 1'b0;
        @(posedge clk);
        while (expected_temps.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // write all three registers on consecutive cycles, block idle
    task automatic set_config(input logic [CFG_W-1:0] series, input logic [CFG_W-1:0] lo,
                              input logic [CFG_W-1:0] hi);
        cfg_we <= 1'b1;
        cfg_index <= REG_SERIES_RES;
        cfg_wdata <= series;
        @(posedge clk);
        cfg_index <= REG_MIN_RES;
        cfg_wdata <= lo;
        @(posedge clk);
        cfg_index <= REG_MAX_RES;
        cfg_wdata <= hi;
        @(posedge clk);
        cfg_we <= 1'b0;
        series_ohms = series;
        min_ohms = lo;
        max_ohms = hi;
        settings_used++;
        @(posedge clk);
    endtask

    // reset values, exact table hit, both clamps, full scale, beyond both table ends
    task automatic test_directed_corners();
        send_sample(12'd0, draw_gap());
        send_sample(12'd1, draw_gap());
        send_sample(12'd2048, draw_gap());
        send_sample(12'd4094, draw_gap());
        send_sample(12'd4095, draw_gap());
        wait_drained();
        // lower clamp lands exactly on the 25 C entry
        set_config(24'd100000, 24'd100000, MAX_RES_RST);
        send_sample(12'd0, draw_gap());
        send_sample(12'd1000, draw_gap());
        send_sample(12'd3000, draw_gap());
        wait_drained();
        // open limits: zero resistance is hotter than the table, huge is colder
        set_config(CFG_MAX, 24'd0, CFG_MAX);
        send_sample(12'd0, draw_gap());
        send_sample(12'd1, draw_gap());
        send_sample(12'd4094, draw_gap());
        send_sample(12'd4095, draw_gap());
        send_sample(12'hAAA, draw_gap());
        send_sample(12'h555, draw_gap());
        wait_drained();
        set_config(24'd1, 24'd0, CFG_MAX);
        send_sample(12'd4094, draw_gap());
        send_sample(12'd4095, draw_gap());
        send_sample(12'd1, draw_gap());
    endtask

    // one register setting, then a burst of random samples
    task automatic run_random_phase(input logic [CFG_W-1:0] series, input logic [CFG_W-1:0] lo,
                                    input logic [CFG_W-1:0] hi, input int count);
        logic [RAW_W-1:0] raw;
        wait_drained();
        set_config(series, lo, hi);
        for (int n = 0; n < count; n++)
        begin
            case ($urandom_range(0, 19))
                0: raw = 12'd0;
                1: raw = 12'd4095;
                2: raw = 12'(4095 - $urandom_range(1, 8));
                3: raw = 12'($urandom_range(1, 8));
                default: raw = 12'($urandom_range(0, 4095));
            endcase
            send_sample(raw, draw_gap());
        end
    endtask

    // random samples across several register settings, extremes included
    task automatic test_random_settings();
        logic [CFG_W-1:0] v;
        run_random_phase(SERIES_RES_RST, MIN_RES_RST, MAX_RES_RST, 190);
        run_random_phase(24'd1, 24'd0, CFG_MAX, 190);
        run_random_phase(CFG_MAX, 24'd0, CFG_MAX, 190);
        run_random_phase(24'($urandom_range(1000, 500000)), 24'd0, CFG_MAX, 190);
        run_random_phase(24'($urandom_range(1, 16777215)), 24'($urandom_range(0, 20000)),
                         24'($urandom_range(1000000, 16777215)), 190);
        v = 24'($urandom_range(1000, 1000000));
        run_random_phase(24'($urandom_range(1000, 1000000)), v, v, 190);
        run_random_phase(SERIES_RES_RST, CFG_MAX, 24'd0, 190);
        run_random_phase(24'($urandom_range(1, 16777215)), 24'($urandom_range(0, 16777215)),
                         24'($urandom_range(0, 16777215)), 190);
    endtask

    // receiver holds off while samples keep coming, so the input stalls
    task automatic test_output_backpressure();
        wait_drained();
        set_config(SERIES_RES_RST, MIN_RES_RST, MAX_RES_RST);
        stall_requests++;
        for (int n = 0; n < 30; n++)
            send_sample(12'($urandom_range(0, 4095)), 0);
    endtask

    // test sequence
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_corners();
        test_random_settings();
        test_output_backpressure();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("checked %0d of %0d samples over %0d register settings", temps_checked,
                 samples_sent, settings_used);
        $display("included both clamps, inverted limits, full scale and a %0d-cycle stall",
                 STALL_CYCLES);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
